FILE: hw/rtl/signed_int_to_decimal_ascii_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII unit
// Shared helpers that wrap clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Checks an implication in the same cycle.
`define SIDT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Checks an implication in the next cycle.
`define SIDT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sidt_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII package
// Shared constants, types and helper functions of the conversion unit.
// ----------------------------------------------------------------------------
package sidt_pkg;

  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned CharBits     = 7;

  localparam logic [CharBits-1:0] AsciiMinus = 7'h2d;
  localparam logic [CharBits-1:0] AsciiZero  = 7'h30;
  localparam logic [CharBits-1:0] AsciiNine  = 7'h39;

  typedef struct packed {
    logic empty;
    logic full;
  } sidt_q_status_t;

  // One correction step of the shift-and-add-three binary to BCD conversion.
  function automatic logic [3:0] bcd_adj(input logic [3:0] digit);
    logic [3:0] res;
    res = (digit >= 4'd5) ? digit + 4'd3 : digit;
    return res;
  endfunction

endpackage

FILE: hw/rtl/sidt_if.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII channels
// Valid/ready interfaces for the integer input and the character output.
// ----------------------------------------------------------------------------
interface sidt_in_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

FILE: hw/rtl/sidt_front.sv
// ----------------------------------------------------------------------------
// Front end of the conversion unit
// Accepts integers, splits them into sign and magnitude and queues them.
// ----------------------------------------------------------------------------
module sidt_front import sidt_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  sidt_in_if.sink              in_i,
  input  sidt_q_status_t       q_status_i,
  output logic                 push_o,
  output logic [VALUE_BITS:0]  entry_o
);

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  // The negation is taken at full width, so the most negative value
  // yields its exact magnitude as an unsigned number.
  assign neg     = in_i.value[VALUE_BITS-1];
  assign mag     = neg ? (~in_i.value + VALUE_BITS'(1)) : in_i.value;
  assign in_i.ready = !q_status_i.full;
  assign push_o  = in_i.valid && !q_status_i.full;
  assign entry_o = {neg, mag};

endmodule

FILE: hw/rtl/sidt_queue.sv
// ----------------------------------------------------------------------------
// Two-entry queue between front and back end
// Lets the front accept a new integer while the back is still converting.
// ----------------------------------------------------------------------------
module sidt_queue import sidt_pkg::*; #(
  parameter int unsigned WIDTH = ValueBitsDef + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] entry_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] entry_o,
  output sidt_q_status_t   status_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.empty = (cnt_q == 2'd0);
  assign status_o.full  = (cnt_q == 2'd2);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign entry_o        = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: hw/rtl/sidt_back.sv
// ----------------------------------------------------------------------------
// Back end of the conversion unit
// Converts a magnitude to BCD bit by bit and sends the text one character
// per beat, most significant first, with leading zeros dropped.
// ----------------------------------------------------------------------------
module sidt_back import sidt_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [VALUE_BITS:0] entry_i,
  input  sidt_q_status_t      q_status_i,
  output logic                pop_o,
  sidt_out_if.source          out_o
);

  localparam int unsigned NumDigits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned BitCntW   = $clog2(VALUE_BITS);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StConv  = 4'b0010,
    StSign  = 4'b0100,
    StDigit = 4'b1000
  } sidt_state_e;

  sidt_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [BcdW-1:0]       bcd_adj_v;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic                  started_q, started_d;
  logic                  out_valid_q;
  logic [CharBits-1:0]   out_char_q;
  logic                  out_last_q;
  logic                  slot_free;
  logic                  emit;
  logic [CharBits-1:0]   emit_char;
  logic                  emit_last;
  logic [3:0]            top_digit;

  assign slot_free = !out_valid_q || out_o.ready;
  assign top_digit = bcd_q[BcdW-1 -: 4];

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj_v[i*4 +: 4] = bcd_adj(bcd_q[i*4 +: 4]);
    end
  end

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    started_d = started_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_char = AsciiZero;
    emit_last = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!q_status_i.empty) begin
          pop_o     = 1'b1;
          mag_d     = entry_i[VALUE_BITS-1:0];
          neg_d     = entry_i[VALUE_BITS];
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = StConv;
        end
      end
      StConv: begin
        bcd_d     = {bcd_adj_v[BcdW-2:0], mag_q[VALUE_BITS-1]};
        mag_d     = mag_q << 1;
        bit_cnt_d = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitCntW'(VALUE_BITS - 1)) begin
          dig_cnt_d = DigCntW'(NumDigits - 1);
          started_d = 1'b0;
          state_d   = neg_q ? StSign : StDigit;
        end
      end
      StSign: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = AsciiMinus;
          state_d   = StDigit;
        end
      end
      StDigit: begin
        if (top_digit == 4'd0 && !started_q && dig_cnt_q != '0) begin
          bcd_d     = bcd_q << 4;
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = AsciiZero + {3'b000, top_digit};
          emit_last = (dig_cnt_q == '0);
          bcd_d     = bcd_q << 4;
          started_d = 1'b1;
          if (dig_cnt_q == '0) begin
            state_d = StIdle;
          end else begin
            dig_cnt_d = dig_cnt_q - DigCntW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    bcd_q <= bcd_d;
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = out_char_q;
  assign out_o.last       = out_last_q;

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
// An integer passes through the queue, is converted to BCD bit by bit, then is
// sent one character per cycle while the receiver is ready; each dropped
// leading zero is shifted out in a step of its own, with no character sent.
// The back end converts one integer at a time; the queue buffers two more.
// Reset clears the queue, the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII unit
// Top level: front end, two-entry queue and back end converter.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit import sidt_pkg::*; #(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sidt_in_if.sink    in_i,
  sidt_out_if.source out_o
);

  logic                push;
  logic                pop;
  logic [VALUE_BITS:0] push_entry;
  logic [VALUE_BITS:0] pop_entry;
  sidt_q_status_t      q_status;

  sidt_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sidt_queue #(
    .WIDTH (VALUE_BITS + 1)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  sidt_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (pop_entry),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

FILE: hw/rtl/sidt_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the signed integer to decimal ASCII unit
// Watches the output channel for handshake and character rules.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sidt_checker import sidt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [CharBits-1:0] out_char_i,
  input logic                out_last_i
);

  `SIDT_ASSERT_NEXT(a_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output beat dropped while stalled")
  `SIDT_ASSERT_SAME(a_char_legal, clk_i, rst_ni, out_valid_i, out_char_i == AsciiMinus || (out_char_i >= AsciiZero && out_char_i <= AsciiNine), "illegal output character")
  `SIDT_ASSERT_SAME(a_minus_not_last, clk_i, rst_ni, out_valid_i && out_char_i == AsciiMinus, !out_last_i, "minus sign marked as last beat")
  `SIDT_ASSERT_NEXT(a_minus_then_digit, clk_i, rst_ni, out_valid_i && out_ready_i && out_char_i == AsciiMinus, !out_valid_i || out_char_i != AsciiMinus, "minus sign followed by minus sign")

endmodule

bind signed_int_to_decimal_ascii_unit sidt_checker u_sidt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.ascii_char),
  .out_last_i  (out_o.last)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII unit
// A table of directed integers is sent first, followed by a mixed random
// stream, with bursty input beats and a receiver that stalls on its own.
// Every character beat is checked against text predicted at acceptance.
// ----------------------------------------------------------------------------
module tb_top;
  import sidt_pkg::*;

  localparam int unsigned VALUE_BITS  = 32;
  localparam int          ROWS        = 20;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          DRAIN_CYCLES = 2 * VALUE_BITS + 24;

  typedef struct packed {
    logic [CharBits-1:0] ascii_char;
    logic                last;
  } text_char_t;

  logic clk_i;
  logic rst_ni;

  sidt_in_if #(.VALUE_BITS(VALUE_BITS)) in_bus ();
  sidt_out_if out_bus ();

  signed_int_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  text_char_t pending_chars [$];
  int         mismatches;
  bit         steady_flow;

  int row_value [ROWS] = '{
    0, 1, -1, 9, 10, -10, 2147483647, int'(32'h8000_0000), -2147483647,
    1000000000, -1000000000, 999999999, 12345, -7,
    100, -99, int'(32'h5555_5555), int'(32'hAAAA_AAAA), int'(32'h0000_FFFF),
    int'(32'hFFFF_0000)
  };

  string row_text [ROWS] = '{
    "0", "1", "-1", "9", "10", "-10", "2147483647", "-2147483648", "-2147483647",
    "1000000000", "-1000000000", "999999999", "12345", "-7",
    "", "", "", "", "", ""
  };

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  task automatic predict_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digit [20];
    int                    n;
    n = 0;
    mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    do begin
      digit[n] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) begin
      pending_chars.push_back('{ascii_char: AsciiMinus, last: 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back('{ascii_char: AsciiZero + CharBits'(digit[i]),
                                last: (i == 0)});
    end
  endtask

  task automatic queue_literal_text(input string text);
    logic [7:0] c;
    for (int i = 0; i < text.len(); i++) begin
      c = text[i];
      pending_chars.push_back('{ascii_char: c[CharBits-1:0],
                                last: (i == text.len() - 1)});
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    longint mag;
    longint lo;
    longint hi;
    int     pick;
    int     k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      return $urandom;
    end
    if (pick < 70) begin
      k = $urandom_range(1, 10);
      lo = 1;
      for (int i = 1; i < k; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (k == 1) lo = 0;
      if (hi > 64'd2147483647) hi = 64'd2147483647;
      mag = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
    end else if (pick < 85) begin
      k = $urandom_range(0, 9);
      mag = 1;
      for (int i = 0; i < k; i++) mag = mag * 10;
      mag = mag + $urandom_range(0, 4) - 2;
      if (mag < 0) mag = 0;
    end else begin
      mag = $urandom_range(0, 20);
    end
    if ($urandom_range(0, 1) == 1) begin
      return VALUE_BITS'(-mag);
    end
    return VALUE_BITS'(mag);
  endfunction

  task automatic send_value(input logic [VALUE_BITS-1:0] value, input string text);
    in_bus.valid <= 1'b1;
    in_bus.value <= value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (text.len() != 0) begin
      queue_literal_text(text);
    end else begin
      predict_text(value);
    end
    @(negedge clk_i);
  endtask

  task automatic send_with_gaps(input logic [VALUE_BITS-1:0] value, input string text,
                                inout int burst_left);
    int gap;
    if (burst_left == 0) begin
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    send_value(value, text);
    burst_left--;
  endtask

  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int hold_left;
    out_bus.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_bus.ready <= 1'b0;
      end else if (steady_flow) begin
        out_bus.ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (out_bus.ready) begin
        out_bus.ready <= 1'b0;
        hold_left = $urandom_range(0, 5);
      end else begin
        out_bus.ready <= 1'b1;
        hold_left = $urandom_range(0, 11);
      end
    end
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, actual char %h last %b", $realtime,
                 out_bus.ascii_char, out_bus.last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_bus.ascii_char !== want.ascii_char) begin
          $display("%0t: ascii_char mismatch, expected %h actual %h", $realtime,
                   want.ascii_char, out_bus.ascii_char);
          mismatches++;
        end
        if (out_bus.last !== want.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $realtime,
                   want.last, out_bus.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int burst_left;
    mismatches   = 0;
    steady_flow  = 1'b0;
    burst_left   = 0;
    in_bus.valid = 1'b0;
    in_bus.value = '0;
    rst_ni       = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < ROWS; r++) begin
      send_with_gaps(VALUE_BITS'(row_value[r]), row_text[r], burst_left);
    end
    wait_for_drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) begin
        wait_for_drain();
      end
      steady_flow = (n >= 120 && n < 170);
      send_with_gaps(random_value(), "", burst_left);
    end
    steady_flow = 1'b0;
    in_bus.valid <= 1'b0;

    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
